### hdl/tekm_pkg.sv
// Types and constants shared by the terminal key and mouse decoder.
package tekm_pkg;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_ESC  = 5'b00010,
		PH_CSI  = 5'b00100,
		PH_SGR  = 5'b01000,
		PH_X10  = 5'b10000
	} phase_t;

	localparam logic [3:0] EV_QUIT     = 4'd0;
	localparam logic [3:0] EV_DIGIT    = 4'd1;
	localparam logic [3:0] EV_DRIVER   = 4'd2;
	localparam logic [3:0] EV_CODRIVER = 4'd3;
	localparam logic [3:0] EV_LEFT     = 4'd4;
	localparam logic [3:0] EV_RIGHT    = 4'd5;
	localparam logic [3:0] EV_UP       = 4'd6;
	localparam logic [3:0] EV_DOWN     = 4'd7;
	localparam logic [3:0] EV_REFRESH  = 4'd8;
	localparam logic [3:0] EV_ENTER    = 4'd9;
	localparam logic [3:0] EV_CLICK    = 4'd10;

	// SGR number being parsed
	localparam logic [1:0] FLD_BTN  = 2'd0;
	localparam logic [1:0] FLD_COL  = 2'd1;
	localparam logic [1:0] FLD_ROW  = 2'd2;
	localparam logic [1:0] FLD_TAIL = 2'd3;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] field;
		logic       seen;
		logic       mal;
		logic [1:0] x10_cnt;
	} ctl_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [7:0]  digit_char;
		logic [15:0] mouse_col;
		logic [15:0] mouse_row;
	} event_t;

	typedef struct packed {
		logic   hit;
		event_t ev;
	} key_t;

endpackage

### hdl/tekm_byte_if.sv
// Byte channel into the decoder.
interface tekm_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

### hdl/tekm_event_if.sv
// Event channel out of the decoder.
interface tekm_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [7:0]  digit_char;
	logic [15:0] mouse_col;
	logic [15:0] mouse_row;

	modport source (output valid, output event_kind, output digit_char,
		output mouse_col, output mouse_row, input ready);
	modport sink (input valid, input event_kind, input digit_char,
		input mouse_col, input mouse_row, output ready);
endinterface

### hdl/terminal_escape_key_mouse_decoder.sv
// Top level of the terminal key and mouse decoder.
//
// Usage:
//   term: one raw terminal byte per beat (valid/ready, in_byte).
//   evt:  one decoded event per beat (event_kind, digit_char, mouse_col,
//         mouse_row); columns and rows are zero-based, zero for non-clicks.
//   Bytes that complete no event (escape prefixes, mouse report bodies,
//   unmapped keys) give no beat on evt.
// Timing:
//   A byte is registered on acceptance and decoded from that register into
//   the event register, from which its event is offered. One byte is taken
//   every cycle while evt is not stalled; the rate is set by the single
//   decode stage between the byte register and the event register.
// Reset (arst_n low): parser back to idle, SGR numbers cleared, both
//   register stages emptied.
// Stall: while evt.ready is low a pending event holds; one more byte may sit
//   in the input register, after which term.ready drops until evt drains.
module terminal_escape_key_mouse_decoder #(
	parameter int COORD_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	tekm_byte_if.sink    term,
	tekm_event_if.source evt
);

	logic                  valid_s1;
	logic [7:0]            in_byte_s1;
	logic                  valid_s2;
	tekm_pkg::event_t      res_s2;
	tekm_pkg::ctl_t        ctl_q;
	logic [COORD_BITS-1:0] btn_q;
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic [7:0]            x10_btn_q;
	logic [7:0]            x10_col_q;

	tekm_pkg::ctl_t        ctl_nxt;
	logic [COORD_BITS-1:0] btn_nxt;
	logic [COORD_BITS-1:0] col_nxt;
	logic [COORD_BITS-1:0] row_nxt;
	logic [7:0]            x10_btn_nxt;
	logic [7:0]            x10_col_nxt;
	logic                  emit;
	tekm_pkg::event_t      res;
	logic                  adv;
	logic                  fire;

	assign adv        = !valid_s2 || evt.ready;
	assign fire       = valid_s1 && adv;
	assign term.ready = !valid_s1 || adv;

	tekm_step #(
		.COORD_BITS(COORD_BITS)
	) u_step (
		.in_byte     (in_byte_s1),
		.ctl         (ctl_q),
		.btn         (btn_q),
		.col         (col_q),
		.row         (row_q),
		.x10_btn     (x10_btn_q),
		.x10_col     (x10_col_q),
		.ctl_nxt     (ctl_nxt),
		.btn_nxt     (btn_nxt),
		.col_nxt     (col_nxt),
		.row_nxt     (row_nxt),
		.x10_btn_nxt (x10_btn_nxt),
		.x10_col_nxt (x10_col_nxt),
		.emit        (emit),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctl_q    <= '{phase: tekm_pkg::PH_IDLE, field: tekm_pkg::FLD_BTN,
				seen: 1'b0, mal: 1'b0, x10_cnt: 2'd0};
			btn_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (term.ready) begin
				valid_s1 <= term.valid;
			end
			if (adv) begin
				valid_s2 <= fire && emit;
			end
			if (fire) begin
				ctl_q <= ctl_nxt;
				btn_q <= btn_nxt;
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (term.ready && term.valid) begin
			in_byte_s1 <= term.in_byte;
		end
		if (fire) begin
			x10_btn_q <= x10_btn_nxt;
			x10_col_q <= x10_col_nxt;
		end
		if (fire && emit) begin
			res_s2 <= res;
		end
	end

	assign evt.valid      = valid_s2;
	assign evt.event_kind = res_s2.event_kind;
	assign evt.digit_char = res_s2.digit_char;
	assign evt.mouse_col  = res_s2.mouse_col;
	assign evt.mouse_row  = res_s2.mouse_row;

`ifndef SYNTHESIS
	a_new_event_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !$past(valid_s2)) |-> $past(valid_s1))
		else $error("event appeared without a decoded byte");

	a_coords_only_on_click: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_kind != tekm_pkg::EV_CLICK)
		|-> (res_s2.mouse_col == 16'd0 && res_s2.mouse_row == 16'd0))
		else $error("non-click event carries coordinates");

	a_char_only_on_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_kind != tekm_pkg::EV_DIGIT)
		|-> res_s2.digit_char == 8'd0)
		else $error("non-digit event carries a character");

	a_x10_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.x10_cnt != 2'd3)
		else $error("X10 byte count out of range");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !evt.ready) |=> $stable(ctl_q))
		else $error("parser advanced while result stalled");
`endif

endmodule

### hdl/tekm_step.sv
// Next-state and event logic for one received byte.
module tekm_step #(
	parameter int COORD_BITS = 16
) (
	input  logic [7:0]            in_byte,
	input  tekm_pkg::ctl_t        ctl,
	input  logic [COORD_BITS-1:0] btn,
	input  logic [COORD_BITS-1:0] col,
	input  logic [COORD_BITS-1:0] row,
	input  logic [7:0]            x10_btn,
	input  logic [7:0]            x10_col,
	output tekm_pkg::ctl_t        ctl_nxt,
	output logic [COORD_BITS-1:0] btn_nxt,
	output logic [COORD_BITS-1:0] col_nxt,
	output logic [COORD_BITS-1:0] row_nxt,
	output logic [7:0]            x10_btn_nxt,
	output logic [7:0]            x10_col_nxt,
	output logic                  emit,
	output tekm_pkg::event_t      res
);

	localparam int CW = (COORD_BITS > 16) ? COORD_BITS : 16;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MIN  = 8'h2D;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UB   = 8'h42;
	localparam logic [7:0] CH_UC   = 8'h43;
	localparam logic [7:0] CH_UD   = 8'h44;
	localparam logic [7:0] CH_UM   = 8'h4D;
	localparam logic [7:0] CH_UZ   = 8'h5A;
	localparam logic [7:0] CH_LM   = 8'h6D;
	localparam logic [7:0] CH_C    = 8'h63;
	localparam logic [7:0] CH_D    = 8'h64;
	localparam logic [7:0] CH_H    = 8'h68;
	localparam logic [7:0] CH_J    = 8'h6A;
	localparam logic [7:0] CH_K    = 8'h6B;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_Q    = 8'h71;
	localparam logic [7:0] CH_R    = 8'h72;
	localparam logic [7:0] X10_OFS = 8'd33;

	function automatic tekm_pkg::key_t plain_key(input logic [7:0] b);
		logic [7:0]     lc;
		tekm_pkg::key_t k;
		lc = (b >= CH_UA && b <= CH_UZ) ? (b | 8'h20) : b;
		k = '0;
		k.hit = 1'b1;
		if (lc == CH_Q)
			k.ev.event_kind = tekm_pkg::EV_QUIT;
		else if ((b >= CH_0 && b <= CH_9) || b == CH_PLUS || b == CH_MIN) begin
			k.ev.event_kind = tekm_pkg::EV_DIGIT;
			k.ev.digit_char = b;
		end else if (lc == CH_D)
			k.ev.event_kind = tekm_pkg::EV_DRIVER;
		else if (lc == CH_C)
			k.ev.event_kind = tekm_pkg::EV_CODRIVER;
		else if (lc == CH_H)
			k.ev.event_kind = tekm_pkg::EV_LEFT;
		else if (lc == CH_L)
			k.ev.event_kind = tekm_pkg::EV_RIGHT;
		else if (lc == CH_K)
			k.ev.event_kind = tekm_pkg::EV_UP;
		else if (lc == CH_J)
			k.ev.event_kind = tekm_pkg::EV_DOWN;
		else if (lc == CH_R)
			k.ev.event_kind = tekm_pkg::EV_REFRESH;
		else if (b == CH_LF || b == CH_CR)
			k.ev.event_kind = tekm_pkg::EV_ENTER;
		else
			k.hit = 1'b0;
		return k;
	endfunction

	logic                  digit;
	logic                  plain;
	logic                  sgr_ok;
	logic [COORD_BITS-1:0] acc_sel;
	logic [COORD_BITS+3:0] acc_x10;
	logic [COORD_BITS-1:0] acc_sat;
	logic [COORD_BITS-1:0] col_m1;
	logic [COORD_BITS-1:0] row_m1;
	logic [CW-1:0]         col_w;
	logic [CW-1:0]         row_w;
	logic [7:0]            x10_c;
	logic [7:0]            x10_r;
	tekm_pkg::key_t        pk;

	assign digit = (in_byte >= CH_0) && (in_byte <= CH_9);

	// decimal accumulate with saturation, on the number being parsed
	always_comb begin
		case (ctl.field)
			tekm_pkg::FLD_BTN: acc_sel = btn;
			tekm_pkg::FLD_COL: acc_sel = col;
			default:           acc_sel = row;
		endcase
		acc_x10 = ({4'b0, acc_sel} << 3) + ({4'b0, acc_sel} << 1)
			+ (COORD_BITS+4)'(in_byte - CH_0);
		acc_sat = (acc_x10[COORD_BITS+3:COORD_BITS] != 4'd0) ? '1
			: acc_x10[COORD_BITS-1:0];
	end

	assign sgr_ok = !ctl.mal && (ctl.field == tekm_pkg::FLD_TAIL
		|| (ctl.field == tekm_pkg::FLD_ROW && ctl.seen))
		&& !btn[0] && !btn[1] && !btn[5] && !btn[6];

	assign col_m1 = (col == '0) ? '0 : col - 1'b1;
	assign row_m1 = (row == '0) ? '0 : row - 1'b1;
	assign col_w  = CW'(col_m1);
	assign row_w  = CW'(row_m1);
	assign x10_c  = (x10_col > X10_OFS) ? x10_col - X10_OFS : 8'd0;
	assign x10_r  = (in_byte > X10_OFS) ? in_byte - X10_OFS : 8'd0;
	assign pk     = plain_key(in_byte);

	always_comb begin
		ctl_nxt     = ctl;
		btn_nxt     = btn;
		col_nxt     = col;
		row_nxt     = row;
		x10_btn_nxt = x10_btn;
		x10_col_nxt = x10_col;
		emit        = 1'b0;
		res         = '0;
		plain       = 1'b0;
		unique case (ctl.phase)
			tekm_pkg::PH_ESC: begin
				if (in_byte == CH_LBR) begin
					ctl_nxt.phase = tekm_pkg::PH_CSI;
				end else begin
					ctl_nxt.phase = tekm_pkg::PH_IDLE;
					plain = 1'b1;
				end
			end
			tekm_pkg::PH_CSI: begin
				ctl_nxt.phase = tekm_pkg::PH_IDLE;
				case (in_byte)
					CH_UA: begin
						emit = 1'b1;
						res.event_kind = tekm_pkg::EV_UP;
					end
					CH_UB: begin
						emit = 1'b1;
						res.event_kind = tekm_pkg::EV_DOWN;
					end
					CH_UC: begin
						emit = 1'b1;
						res.event_kind = tekm_pkg::EV_RIGHT;
					end
					CH_UD: begin
						emit = 1'b1;
						res.event_kind = tekm_pkg::EV_LEFT;
					end
					CH_LT: begin
						ctl_nxt.phase = tekm_pkg::PH_SGR;
						ctl_nxt.field = tekm_pkg::FLD_BTN;
						ctl_nxt.seen  = 1'b0;
						ctl_nxt.mal   = 1'b0;
						btn_nxt = '0;
						col_nxt = '0;
						row_nxt = '0;
					end
					CH_UM: begin
						ctl_nxt.phase   = tekm_pkg::PH_X10;
						ctl_nxt.x10_cnt = 2'd0;
					end
					default: plain = 1'b1;
				endcase
			end
			tekm_pkg::PH_SGR: begin
				if (in_byte == CH_LM || in_byte == CH_UM) begin
					ctl_nxt.phase = tekm_pkg::PH_IDLE;
					ctl_nxt.field = tekm_pkg::FLD_BTN;
					ctl_nxt.seen  = 1'b0;
					ctl_nxt.mal   = 1'b0;
					btn_nxt = '0;
					col_nxt = '0;
					row_nxt = '0;
					if (sgr_ok) begin
						emit = 1'b1;
						res.event_kind = tekm_pkg::EV_CLICK;
						res.mouse_col  = col_w[15:0];
						res.mouse_row  = row_w[15:0];
					end
				end else if (!ctl.mal && ctl.field != tekm_pkg::FLD_TAIL) begin
					if (digit) begin
						case (ctl.field)
							tekm_pkg::FLD_BTN: btn_nxt = acc_sat;
							tekm_pkg::FLD_COL: col_nxt = acc_sat;
							default:           row_nxt = acc_sat;
						endcase
						ctl_nxt.seen = 1'b1;
					end else if (!ctl.seen) begin
						ctl_nxt.mal = 1'b1;
					end else if (ctl.field == tekm_pkg::FLD_ROW) begin
						ctl_nxt.field = tekm_pkg::FLD_TAIL;
					end else if (in_byte == CH_SEMI) begin
						ctl_nxt.field = ctl.field + 2'd1;
						ctl_nxt.seen  = 1'b0;
					end else begin
						ctl_nxt.mal = 1'b1;
					end
				end
			end
			tekm_pkg::PH_X10: begin
				case (ctl.x10_cnt)
					2'd0: begin
						x10_btn_nxt     = in_byte;
						ctl_nxt.x10_cnt = 2'd1;
					end
					2'd1: begin
						x10_col_nxt     = in_byte;
						ctl_nxt.x10_cnt = 2'd2;
					end
					default: begin
						ctl_nxt.x10_cnt = 2'd0;
						ctl_nxt.phase   = tekm_pkg::PH_IDLE;
						if (!x10_btn[6]) begin
							emit = 1'b1;
							res.event_kind = tekm_pkg::EV_CLICK;
							res.mouse_col  = {8'd0, x10_c};
							res.mouse_row  = {8'd0, x10_r};
						end
					end
				endcase
			end
			default: begin
				ctl_nxt.phase = tekm_pkg::PH_IDLE;
				plain = 1'b1;
			end
		endcase
		if (plain) begin
			if (in_byte == CH_ESC) begin
				ctl_nxt.phase = tekm_pkg::PH_ESC;
			end else begin
				emit = pk.hit;
				res  = pk.hit ? pk.ev : '0;
			end
		end
	end

endmodule

### test/terminal_escape_key_mouse_decoder_tb.sv
// Self-checking testbench for the terminal key and mouse decoder: byte stream in, events checked.
module terminal_escape_key_mouse_decoder_tb;

	localparam logic [7:0] ESC_CODE = 8'h1B;
	localparam logic [7:0] LF_CODE  = 8'h0A;
	localparam logic [7:0] CR_CODE  = 8'h0D;
	localparam logic [15:0] COORD_SAT = 16'hFFFF;
	localparam int unsigned RANDOM_BYTES = 1370;

	logic clk;
	logic arst_n;

	tekm_byte_if  term_if ();
	tekm_event_if evt_if ();

	terminal_escape_key_mouse_decoder #(.COORD_BITS(16)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.term   (term_if),
		.evt    (evt_if)
	);

	// decoder shadow state
	tekm_pkg::phase_t ph;
	logic [15:0] btn_acc, col_acc, row_acc;
	logic [1:0]  fld;
	bit          seen, mal;
	logic [1:0]  x10_cnt;
	logic [7:0]  x10_btn, x10_col;

	logic [7:0]  tx_bytes[$];
	tekm_pkg::event_t pending_events[$];
	int unsigned pause_at[$];
	int unsigned issued, accepted, total_bytes, errors;
	int unsigned gap_left, gap_rate, stall_left, stall_rate;
	bit          calm;

	function automatic logic [15:0] sat_acc(logic [15:0] acc, logic [7:0] b);
		int unsigned v;
		v = 32'(acc) * 10 + 32'(b) - 32'd48;
		return (v > 32'(COORD_SAT)) ? COORD_SAT : v[15:0];
	endfunction

	function automatic void clear_sgr();
		btn_acc = '0;
		col_acc = '0;
		row_acc = '0;
		fld = tekm_pkg::FLD_BTN;
		seen = 1'b0;
		mal = 1'b0;
	endfunction

	function automatic bit map_key(logic [7:0] b, output tekm_pkg::event_t ev);
		logic [7:0] lc;
		lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		ev = '0;
		map_key = 1'b1;
		if (b == ESC_CODE) begin
			ph = tekm_pkg::PH_ESC;
			map_key = 1'b0;
		end else if (lc == "q") ev.event_kind = tekm_pkg::EV_QUIT;
		else if ((b >= "0" && b <= "9") || b == "+" || b == "-") begin
			ev.event_kind = tekm_pkg::EV_DIGIT;
			ev.digit_char = b;
		end else if (lc == "d") ev.event_kind = tekm_pkg::EV_DRIVER;
		else if (lc == "c") ev.event_kind = tekm_pkg::EV_CODRIVER;
		else if (lc == "h") ev.event_kind = tekm_pkg::EV_LEFT;
		else if (lc == "l") ev.event_kind = tekm_pkg::EV_RIGHT;
		else if (lc == "k") ev.event_kind = tekm_pkg::EV_UP;
		else if (lc == "j") ev.event_kind = tekm_pkg::EV_DOWN;
		else if (lc == "r") ev.event_kind = tekm_pkg::EV_REFRESH;
		else if (b == LF_CODE || b == CR_CODE) ev.event_kind = tekm_pkg::EV_ENTER;
		else map_key = 1'b0;
	endfunction

	// advances the shadow state by one byte; returns 1 when an event results
	function automatic bit decode_byte(logic [7:0] b, output tekm_pkg::event_t ev);
		logic [15:0] btn, col, row;
		bit ok;
		ev = '0;
		decode_byte = 1'b0;
		case (ph)
		tekm_pkg::PH_ESC: begin
			if (b == "[") ph = tekm_pkg::PH_CSI;
			else begin
				ph = tekm_pkg::PH_IDLE;
				decode_byte = map_key(b, ev);
			end
		end
		tekm_pkg::PH_CSI: begin
			ph = tekm_pkg::PH_IDLE;
			decode_byte = 1'b1;
			if (b == "A") ev.event_kind = tekm_pkg::EV_UP;
			else if (b == "B") ev.event_kind = tekm_pkg::EV_DOWN;
			else if (b == "C") ev.event_kind = tekm_pkg::EV_RIGHT;
			else if (b == "D") ev.event_kind = tekm_pkg::EV_LEFT;
			else if (b == "<") begin
				clear_sgr();
				ph = tekm_pkg::PH_SGR;
				decode_byte = 1'b0;
			end else if (b == "M") begin
				x10_cnt = 2'd0;
				ph = tekm_pkg::PH_X10;
				decode_byte = 1'b0;
			end else decode_byte = map_key(b, ev);
		end
		tekm_pkg::PH_SGR: begin
			if (b == "m" || b == "M") begin
				ok = !mal && (fld == tekm_pkg::FLD_TAIL
					|| (fld == tekm_pkg::FLD_ROW && seen));
				btn = btn_acc;
				col = col_acc;
				row = row_acc;
				ph = tekm_pkg::PH_IDLE;
				clear_sgr();
				if (ok && btn[6:5] == 2'b00 && btn[1:0] == 2'b00) begin
					ev.event_kind = tekm_pkg::EV_CLICK;
					ev.mouse_col = (col != 16'd0) ? col - 16'd1 : 16'd0;
					ev.mouse_row = (row != 16'd0) ? row - 16'd1 : 16'd0;
					decode_byte = 1'b1;
				end
			end else if (mal || fld == tekm_pkg::FLD_TAIL) begin
			end else if (b >= "0" && b <= "9") begin
				if (fld == tekm_pkg::FLD_BTN) btn_acc = sat_acc(btn_acc, b);
				else if (fld == tekm_pkg::FLD_COL) col_acc = sat_acc(col_acc, b);
				else row_acc = sat_acc(row_acc, b);
				seen = 1'b1;
			end else if (!seen) mal = 1'b1;
			else if (fld == tekm_pkg::FLD_ROW) fld = tekm_pkg::FLD_TAIL;
			else if (b == ";") begin
				fld = fld + 2'd1;
				seen = 1'b0;
			end else mal = 1'b1;
		end
		tekm_pkg::PH_X10: begin
			if (x10_cnt == 2'd0) begin
				x10_btn = b;
				x10_cnt = 2'd1;
			end else if (x10_cnt == 2'd1) begin
				x10_col = b;
				x10_cnt = 2'd2;
			end else begin
				x10_cnt = 2'd0;
				ph = tekm_pkg::PH_IDLE;
				if (!x10_btn[6]) begin
					ev.event_kind = tekm_pkg::EV_CLICK;
					ev.mouse_col = (x10_col > 8'd33) ? 16'(x10_col - 8'd33) : 16'd0;
					ev.mouse_row = (b > 8'd33) ? 16'(b - 8'd33) : 16'd0;
					decode_byte = 1'b1;
				end
			end
		end
		default: begin
			ph = tekm_pkg::PH_IDLE;
			decode_byte = map_key(b, ev);
		end
		endcase
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endtask

	task automatic push_csi_head();
		tx_bytes.push_back(ESC_CODE);
		tx_bytes.push_back("[");
	endtask

	function automatic int unsigned pick_coord();
		if ($urandom_range(0, 15) == 0) return $urandom_range(0, 99999);
		return $urandom_range(0, 300);
	endfunction

	function automatic int unsigned pick_button();
		case ($urandom_range(0, 7))
		0, 1, 2, 3: return 0;
		4: return $urandom_range(1, 3);
		5: return 32 + $urandom_range(0, 3);
		6: return 64 + $urandom_range(0, 3);
		default: return $urandom_range(0, 99999);
		endcase
	endfunction

	task automatic add_sgr_report();
		logic [7:0] body[$];
		string s, junk;
		int unsigned n;
		junk = "+- ;\033xm";
		s = $sformatf("%0d;%0d;%0d", pick_button(), pick_coord(), pick_coord());
		for (int i = 0; i < s.len(); i++)
			body.push_back(s[i]);
		case ($urandom_range(0, 9))
		0: body.insert($urandom_range(0, body.size()), junk[$urandom_range(0, junk.len() - 1)]);
		1: body.insert($urandom_range(0, body.size()), 8'($urandom_range(0, 255)));
		2: body.delete($urandom_range(0, body.size() - 1));
		3: begin
			n = $urandom_range(1, 3);
			repeat (n) body.push_back(8'($urandom_range(0, 255)));
		end
		default: ;
		endcase
		push_csi_head();
		tx_bytes.push_back("<");
		foreach (body[i]) tx_bytes.push_back(body[i]);
		tx_bytes.push_back($urandom_range(0, 1) ? "M" : "m");
	endtask

	task automatic add_x10_report();
		push_csi_head();
		tx_bytes.push_back("M");
		case ($urandom_range(0, 3))
		0: tx_bytes.push_back(8'($urandom_range(0, 255)));
		1: tx_bytes.push_back(8'(96 + $urandom_range(0, 3)));
		default: tx_bytes.push_back(8'(32 + $urandom_range(0, 3)));
		endcase
		repeat (2) begin
			if ($urandom_range(0, 2) == 0) tx_bytes.push_back(8'($urandom_range(0, 255)));
			else tx_bytes.push_back(8'($urandom_range(30, 120)));
		end
	endtask

	task automatic add_random_chunk();
		string keys;
		keys = "qQ0123456789+-dDcChHlLkKjJrR\n\r";
		case ($urandom_range(0, 19))
		0, 1, 2, 3, 4, 5: add_sgr_report();
		6, 7, 8: add_x10_report();
		9, 10: begin
			push_csi_head();
			tx_bytes.push_back(8'("A" + $urandom_range(0, 3)));
		end
		11, 12, 13, 14: tx_bytes.push_back(keys[$urandom_range(0, keys.len() - 1)]);
		15, 16: tx_bytes.push_back(8'($urandom_range(0, 255)));
		17: begin
			tx_bytes.push_back(ESC_CODE);
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
		18: begin
			push_csi_head();
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
		default: begin
			tx_bytes.push_back(ESC_CODE);
			tx_bytes.push_back(ESC_CODE);
		end
		endcase
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// byte driver
	always @(posedge clk or negedge arst_n) begin : drive
		tekm_pkg::event_t ev;
		if (!arst_n) begin
			term_if.valid <= 1'b0;
			ph = tekm_pkg::PH_IDLE;
			clear_sgr();
			x10_cnt = 2'd0;
			gap_left = 0;
		end else begin
			if (term_if.valid && term_if.ready) begin
				if (decode_byte(term_if.in_byte, ev))
					pending_events.push_back(ev);
				accepted++;
			end
			calm = tx_bytes.size() < 150;
			if (!term_if.valid || term_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					term_if.valid <= 1'b0;
				end else if (pause_at.size() != 0 && pause_at[0] == issued) begin
					term_if.valid <= 1'b0;
					if (pending_events.size() == 0) void'(pause_at.pop_front());
				end else if (tx_bytes.size() != 0) begin
					term_if.valid <= 1'b1;
					term_if.in_byte <= tx_bytes.pop_front();
					issued++;
					if (issued % 64 == 0) gap_rate = $urandom_range(0, 2) * 3;
					if (!calm && $urandom_range(0, 15) < gap_rate)
						gap_left = $urandom_range(1, 9);
				end else begin
					term_if.valid <= 1'b0;
				end
			end
		end
	end

	// event monitor and checker
	always @(posedge clk or negedge arst_n) begin : watch
		tekm_pkg::event_t want;
		if (!arst_n) begin
			evt_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (evt_if.valid && evt_if.ready) begin
				if (pending_events.size() == 0) begin
					$error("unexpected beat: event_kind %0d", evt_if.event_kind);
					errors++;
				end else begin
					want = pending_events.pop_front();
					check_field("event_kind", 32'(want.event_kind),
						32'(evt_if.event_kind));
					check_field("digit_char", 32'(want.digit_char),
						32'(evt_if.digit_char));
					check_field("mouse_col", 32'(want.mouse_col),
						32'(evt_if.mouse_col));
					check_field("mouse_row", 32'(want.mouse_row),
						32'(evt_if.mouse_row));
				end
			end
			if ($urandom_range(0, 63) == 0) stall_rate = $urandom_range(0, 2) * 3;
			if (stall_left != 0) begin
				stall_left--;
				evt_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) < stall_rate) begin
				stall_left = $urandom_range(0, 8);
				evt_if.ready <= 1'b0;
			end else begin
				evt_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		term_if.valid = 1'b0;
		term_if.in_byte = '0;
		evt_if.ready = 1'b0;
		arst_n = 1'b0;
		issued = 0;
		accepted = 0;
		errors = 0;
		gap_rate = 3;
		stall_rate = 3;
		calm = 1'b0;

		// every key, arrows, clamping, saturation, dropped buttons, malformed reports
		push_text("qQ09+-dDcChHlLkKjJrR\n\r");
		push_text("\033[A\033[B\033[C\033[D");
		push_text("\033[<0;1;1M\033[<0;0;0m\033[<0;99999;70000M\033[<99999;5;5M");
		push_text("\033[<3;9;9M\033[<32;9;9m\033[<64;9;9M\033[<-1;2;3M\033[<;1;1M");
		push_text("\033[<0;5;7xyzM\033[<0;4\033m\033[M !!");
		push_csi_head();
		tx_bytes.push_back("M");
		repeat (3) tx_bytes.push_back(8'hFF);
		push_csi_head();
		tx_bytes.push_back("M");
		tx_bytes.push_back(8'h20);
		tx_bytes.push_back(8'hFF);
		tx_bytes.push_back(8'h00);
		push_text("\033x\033\033[B\033[z");
		pause_at.push_back(tx_bytes.size());
		total_bytes = tx_bytes.size() + RANDOM_BYTES;
		pause_at.push_back(tx_bytes.size() + RANDOM_BYTES / 2);
		while (tx_bytes.size() < total_bytes)
			add_random_chunk();
		total_bytes = tx_bytes.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted != total_bytes) @(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_events.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hdl/tekm_pkg.sv
hdl/tekm_byte_if.sv
hdl/tekm_event_if.sv
hdl/tekm_step.sv
hdl/terminal_escape_key_mouse_decoder.sv
test/terminal_escape_key_mouse_decoder_tb.sv
